// ===== hw/rtl/mpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and constants of the meter pulse qualifier.
// ----------------------------------------------------------------------------
package mpq_pkg;

    localparam int FIELD_BITS = 10;
    localparam int COUNT_BITS = 32;

    // Function codes of an input transaction.
    localparam logic [2:0] FUNC_TICK     = 3'd0;
    localparam logic [2:0] FUNC_A_EDGE   = 3'd1;
    localparam logic [2:0] FUNC_B_EDGE   = 3'd2;
    localparam logic [2:0] FUNC_C_EDGE   = 3'd3;
    localparam logic [2:0] FUNC_A_WINDOW = 3'd4;
    localparam logic [2:0] FUNC_B_WINDOW = 3'd5;

    // Counting modes.
    localparam logic [1:0] MODE_SINGLE   = 2'd1;
    localparam logic [1:0] MODE_TWO_LINE = 2'd2;
    localparam logic [1:0] MODE_SEQUENCE = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MODE    = 2'd0;
    localparam logic [1:0] CFG_MIN_GAP = 2'd1;
    localparam logic [1:0] CFG_MIN_RUN = 2'd2;

    localparam logic [1:0] MODE_RESET    = MODE_TWO_LINE;
    localparam logic [7:0] MIN_GAP_RESET = 8'd10;
    localparam logic [3:0] MIN_RUN_RESET = 4'd8;

    // Sequence stages.
    localparam logic [1:0] STAGE_IDLE   = 2'd0;
    localparam logic [1:0] STAGE_FIRST  = 2'd1;
    localparam logic [1:0] STAGE_SECOND = 2'd2;

    // Operations passed from the classifier to the executor.
    typedef logic [2:0] t_op;
    localparam t_op OP_NONE  = 3'd0;
    localparam t_op OP_TICK  = 3'd1;
    localparam t_op OP_ADD   = 3'd2;
    localparam t_op OP_SEQ_A = 3'd3;
    localparam t_op OP_SEQ_B = 3'd4;
    localparam t_op OP_SEQ_C = 3'd5;
    localparam t_op OP_ARM   = 3'd6;
    localparam t_op OP_COUNT = 3'd7;

    typedef struct packed {
        logic                  counted;
        logic [COUNT_BITS-1:0] pulse_total;
        logic                  armed;
    } t_result;

endpackage

// ===== hw/rtl/mpq_fifo.sv =====
// ----------------------------------------------------------------------------
// mpq_fifo
// Two-entry queue used between the classifier, the executor and the output.
// ----------------------------------------------------------------------------
module mpq_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             n_wr_ptr;
    logic             n_rd_ptr;
    logic [1:0]       n_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == 2'd2);
    assign o_empty   = (r_count == 2'd0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign w_do_pop  = i_pop && !o_empty;
    assign w_do_push = i_push && (!o_full || w_do_pop);

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ w_do_push;
        n_rd_ptr = r_rd_ptr ^ w_do_pop;
        n_count  = r_count + {1'b0, w_do_push} - {1'b0, w_do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

// ===== hw/rtl/mpq_front.sv =====
// ----------------------------------------------------------------------------
// mpq_front
// Classifies an input transaction into one executor operation, including the
// trailing-run test of sample windows.
// ----------------------------------------------------------------------------
module mpq_front
    import mpq_pkg::*;
#(
    parameter int WINDOW_SAMPLES = 10
) (
    input  logic [2:0]            i_func,
    input  logic [FIELD_BITS-1:0] i_samples_a,
    input  logic [FIELD_BITS-1:0] i_samples_b,
    input  logic [1:0]            i_mode,
    input  logic [3:0]            i_min_run,
    output t_op                   o_op
);

    localparam int SPAN = (WINDOW_SAMPLES < FIELD_BITS) ? WINDOW_SAMPLES : FIELD_BITS;

    function automatic logic run_ok(input logic [FIELD_BITS-1:0] match,
                                    input logic [3:0] min_run);
        logic [3:0] run;
        logic       still;
        run   = 4'd0;
        still = 1'b1;
        for (int k = 0; k < SPAN; k++) begin
            if (still && match[FIELD_BITS-1-k]) begin
                run = run + 4'd1;
            end else begin
                still = 1'b0;
            end
        end
        return (run >= min_run);
    endfunction

    logic w_arm_ok;
    logic w_count_ok;

    assign w_arm_ok   = run_ok(~i_samples_a & i_samples_b, i_min_run);
    assign w_count_ok = run_ok(i_samples_a & i_samples_b, i_min_run);

    always_comb begin
        o_op = OP_NONE;
        if (i_func == FUNC_TICK) begin
            o_op = OP_TICK;
        end else begin
            unique case (i_mode)
                MODE_SINGLE: begin
                    if (i_func == FUNC_A_EDGE) o_op = OP_ADD;
                end
                MODE_SEQUENCE: begin
                    if (i_func == FUNC_A_EDGE) o_op = OP_SEQ_A;
                    if (i_func == FUNC_B_EDGE) o_op = OP_SEQ_B;
                    if (i_func == FUNC_C_EDGE) o_op = OP_SEQ_C;
                end
                MODE_TWO_LINE: begin
                    if (i_func == FUNC_A_WINDOW && w_arm_ok)   o_op = OP_ARM;
                    if (i_func == FUNC_B_WINDOW && w_count_ok) o_op = OP_COUNT;
                end
                default: o_op = OP_NONE;
            endcase
        end
    end

endmodule

// ===== hw/rtl/mpq_back.sv =====
// ----------------------------------------------------------------------------
// mpq_back
// Executes classified operations on the tick, arming and pulse state and
// produces one result per operation.
// ----------------------------------------------------------------------------
module mpq_back
    import mpq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_op        i_op,
    input  logic [7:0] i_min_gap,
    output t_result    o_result
);

    logic [COUNT_BITS-1:0] r_tick_now;
    logic [COUNT_BITS-1:0] r_arm_time;
    logic [1:0]            r_stage;
    logic [COUNT_BITS-1:0] r_pulse_count;
    logic [COUNT_BITS-1:0] n_tick_now;
    logic [COUNT_BITS-1:0] n_arm_time;
    logic [1:0]            n_stage;
    logic [COUNT_BITS-1:0] n_pulse_count;
    logic                  w_counted;
    logic [COUNT_BITS-1:0] w_elapsed;
    logic                  w_gap_ok;

    assign w_elapsed = r_tick_now - r_arm_time;
    assign w_gap_ok  = (r_tick_now > r_arm_time) &&
                       (w_elapsed >= {{(COUNT_BITS-8){1'b0}}, i_min_gap});

    always_comb begin
        n_tick_now    = r_tick_now;
        n_arm_time    = r_arm_time;
        n_stage       = r_stage;
        n_pulse_count = r_pulse_count;
        w_counted     = 1'b0;
        unique case (i_op)
            OP_NONE: begin
            end
            OP_TICK: begin
                n_tick_now = r_tick_now + 32'd1;
            end
            OP_ADD: begin
                w_counted = 1'b1;
            end
            OP_SEQ_A: begin
                n_stage = STAGE_FIRST;
            end
            OP_SEQ_B: begin
                if (r_stage == STAGE_FIRST) n_stage = STAGE_SECOND;
            end
            OP_SEQ_C: begin
                if (r_stage == STAGE_SECOND) begin
                    n_stage   = STAGE_IDLE;
                    w_counted = 1'b1;
                end
            end
            OP_ARM: begin
                n_stage    = STAGE_FIRST;
                n_arm_time = r_tick_now;
            end
            OP_COUNT: begin
                if (w_gap_ok && r_stage == STAGE_FIRST) begin
                    n_stage   = STAGE_IDLE;
                    w_counted = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (w_counted) n_pulse_count = r_pulse_count + 32'd1;
    end

    assign o_result.counted     = w_counted;
    assign o_result.pulse_total = n_pulse_count;
    assign o_result.armed       = (n_stage == STAGE_FIRST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_now    <= '0;
            r_arm_time    <= '0;
            r_stage       <= STAGE_IDLE;
            r_pulse_count <= '0;
        end else if (i_valid) begin
            r_tick_now    <= n_tick_now;
            r_arm_time    <= n_arm_time;
            r_stage       <= n_stage;
            r_pulse_count <= n_pulse_count;
        end
    end

endmodule

// ===== hw/rtl/meter_pulse_qualifier_unit.sv =====
// ----------------------------------------------------------------------------
// meter_pulse_qualifier_unit
// Flow-meter pulse qualifier with single-line, two-line and sequence modes.
// ----------------------------------------------------------------------------
// Both sides look like a queue. An input transaction is taken when push is
// high and full is low; each one yields exactly one result, shown while empty
// is low and taken when pop is high. The classifier decodes the function and
// tests the sample-window runs in the cycle of acceptance and writes one
// operation into a two-entry queue. The executor takes one operation a cycle
// from it while the output queue has room, updates the tick, arming and pulse
// state and writes the result into a two-entry output queue. A result passes
// through both queues before it shows on the output ports; one transaction
// per cycle is sustained while the receiver pops every result. When it stops
// popping, the output queue fills, the executor waits, then the operation
// queue fills and full rises; nothing is lost. Reset clears both queues, the
// counters and the sequence stage and loads the register defaults (mode 2,
// gap 10, run 8). Configuration writes take effect at once; the user makes
// them only while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module meter_pulse_qualifier_unit
    import mpq_pkg::*;
#(
    parameter int WINDOW_SAMPLES = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [2:0]            i_func,
    input  logic [FIELD_BITS-1:0] i_samples_a,
    input  logic [FIELD_BITS-1:0] i_samples_b,
    output logic                  empty,
    input  logic                  pop,
    output logic                  o_counted,
    output logic [COUNT_BITS-1:0] o_pulse_total,
    output logic                  o_armed,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [7:0]            i_cfg_wdata
);

    logic [1:0] r_mode;
    logic [7:0] r_min_gap;
    logic [3:0] r_min_run;

    t_op     w_front_op;
    t_op     w_back_op;
    logic    w_op_empty;
    logic    w_op_full;
    logic    w_res_full;
    logic    w_res_room;
    logic    w_issue;
    t_result w_back_result;
    t_result w_out_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_RESET;
            r_min_gap <= MIN_GAP_RESET;
            r_min_run <= MIN_RUN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MODE:    r_mode    <= i_cfg_wdata[1:0];
                CFG_MIN_GAP: r_min_gap <= i_cfg_wdata;
                CFG_MIN_RUN: r_min_run <= i_cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    mpq_front #(
        .WINDOW_SAMPLES(WINDOW_SAMPLES)
    ) u_front (
        .i_func     (i_func),
        .i_samples_a(i_samples_a),
        .i_samples_b(i_samples_b),
        .i_mode     (r_mode),
        .i_min_run  (r_min_run),
        .o_op       (w_front_op)
    );

    mpq_fifo #(
        .WIDTH($bits(t_op))
    ) u_op_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push && !w_op_full),
        .i_wr_data(w_front_op),
        .i_pop    (w_issue),
        .o_full   (w_op_full),
        .o_empty  (w_op_empty),
        .o_rd_data(w_back_op)
    );

    assign full       = w_op_full;
    assign w_res_room = !w_res_full || (pop && !empty);
    assign w_issue    = !w_op_empty && w_res_room;

    mpq_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_issue),
        .i_op     (w_back_op),
        .i_min_gap(r_min_gap),
        .o_result (w_back_result)
    );

    mpq_fifo #(
        .WIDTH($bits(t_result))
    ) u_res_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_issue),
        .i_wr_data(w_back_result),
        .i_pop    (pop),
        .o_full   (w_res_full),
        .o_empty  (empty),
        .o_rd_data(w_out_result)
    );

    assign o_counted     = w_out_result.counted;
    assign o_pulse_total = w_out_result.pulse_total;
    assign o_armed       = w_out_result.armed;

endmodule
